@@ rtl/ddvm_pkg.sv @@
`default_nettype none
package ddvm_pkg;

  localparam int TAB_LEN = 24;
  localparam int SQRT_BITS = 16;
  localparam int QUO_BITS = 15;
  localparam int CW = 36;
  localparam int ZW = 32;
  localparam logic [15:0] ONE_Q15 = 16'h8000;

  localparam logic [2:0] REG_STOP  = 3'd0;
  localparam logic [2:0] REG_CAP   = 3'd1;
  localparam logic [2:0] REG_OVER  = 3'd2;
  localparam logic [2:0] REG_LDUTY = 3'd3;
  localparam logic [2:0] REG_RDUTY = 3'd4;

  typedef struct packed {
    logic valid;
    logic x_nz;
    logic right_side;
    logic y_neg;
  } ctl_t;

  // Rounded atan(2^-i)/pi in half-turns scaled by 2^30.
  function automatic logic [ZW-1:0] atan_entry(input int i);
    logic [ZW-1:0] r;
    unique case (i)
      0: r = 32'd268435456;  1: r = 32'd158466703;  2: r = 32'd83729454;
      3: r = 32'd42502378;   4: r = 32'd21333666;   5: r = 32'd10677233;
      6: r = 32'd5339919;    7: r = 32'd2670123;    8: r = 32'd1335082;
      9: r = 32'd667543;     10: r = 32'd333772;    11: r = 32'd166886;
      12: r = 32'd83443;     13: r = 32'd41722;     14: r = 32'd20861;
      15: r = 32'd10430;     16: r = 32'd5215;      17: r = 32'd2608;
      18: r = 32'd1304;      19: r = 32'd652;       20: r = 32'd326;
      21: r = 32'd163;       22: r = 32'd81;        23: r = 32'd41;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/differential_drive_vector_mapper_unit.sv @@
`default_nettype none
// Maps a signed Q8.8 target vector to left/right wheel PWM duty, a reverse bit and a drive
// enable. Fully pipelined: one request is accepted per cycle while the output is not stalled.
// The bit-per-stage square root runs beside the CORDIC over NS stages, where NS is the larger
// of 16 and CORDIC_STAGES (capped at 24); a 15-stage divider and two multiplier stages follow.
// A stall on the output freezes the whole pipeline and stalls the input.
// Configuration must be written only while no request is in flight.
module differential_drive_vector_mapper_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_target_x,
  input  wire logic [15:0] in_target_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [9:0]       out_left_duty_us,
  output logic [9:0]       out_right_duty_us,
  output logic             out_reverse,
  output logic             out_drive_enable,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  import ddvm_pkg::*;

  localparam int NC = (CORDIC_STAGES > TAB_LEN) ? TAB_LEN : CORDIC_STAGES;
  localparam int NS = (NC > SQRT_BITS) ? NC : SQRT_BITS;

  logic [15:0] stop_r, cap_r, over_r;
  logic [9:0]  lduty_r, rduty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_r  <= 16'd1024;
      cap_r   <= 16'd1536;
      over_r  <= 16'd17920;
      lduty_r <= 10'd550;
      rduty_r <= 10'd600;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STOP:  stop_r  <= cfg_wdata;
        REG_CAP:   cap_r   <= cfg_wdata;
        REG_OVER:  over_r  <= cfg_wdata;
        REG_LDUTY: lduty_r <= cfg_wdata[9:0];
        REG_RDUTY: rduty_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid_r;
  assign adv = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // Input stage: magnitudes and side flags.
  ctl_t        c0_r, c0_nxt;
  logic [15:0] ax0_r, ay0_r, ax0_nxt, ay0_nxt;
  logic signed [15:0] xs, ys;

  always_comb begin
    xs = in_target_x;
    ys = in_target_y;
    ax0_nxt = xs[15] ? 16'(-xs) : in_target_x;
    ay0_nxt = ys[15] ? 16'(-ys) : in_target_y;
    c0_nxt.valid = in_valid;
    c0_nxt.x_nz = (xs != 16'sd0);
    c0_nxt.right_side = (!ys[15]) == (!xs[15] && xs != 16'sd0);
    c0_nxt.y_neg = ys[15];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) c0_r.valid <= 1'b0;
    else if (adv) c0_r.valid <= c0_nxt.valid;
    if (adv) begin
      c0_r.x_nz <= c0_nxt.x_nz;
      c0_r.right_side <= c0_nxt.right_side;
      c0_r.y_neg <= c0_nxt.y_neg;
      ax0_r <= ax0_nxt;
      ay0_r <= ay0_nxt;
    end
  end

  // Squares stage.
  ctl_t        c1_r;
  logic [31:0] sum1_r;
  logic [15:0] ax1_r, ay1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c1_r.valid <= 1'b0;
    else if (adv) c1_r.valid <= c0_r.valid;
    if (adv) begin
      c1_r.x_nz <= c0_r.x_nz;
      c1_r.right_side <= c0_r.right_side;
      c1_r.y_neg <= c0_r.y_neg;
      sum1_r <= 32'(ax0_r * ax0_r) + 32'(ay0_r * ay0_r);
      ax1_r <= ax0_r;
      ay1_r <= ay0_r;
    end
  end

  // Square root (one result bit per stage) beside the vectoring CORDIC.
  ctl_t                  ic_r   [NS+1];
  logic [31:0]           is_r   [NS+1];
  logic [17:0]           irem_r [NS+1];
  logic [15:0]           iroot_r[NS+1];
  logic signed [CW-1:0]  cx_r   [NS+1];
  logic signed [CW-1:0]  cy_r   [NS+1];
  logic signed [ZW-1:0]  z_r    [NS+1];

  always_comb begin
    ic_r[0]    = c1_r;
    is_r[0]    = sum1_r;
    irem_r[0]  = '0;
    iroot_r[0] = '0;
    cx_r[0]    = $signed({4'd0, ax1_r, 16'd0});
    cy_r[0]    = $signed({4'd0, ay1_r, 16'd0});
    z_r[0]     = '0;
  end

  for (genvar k = 0; k < NS; k++) begin : g_iter
    logic [17:0] rem_sh, trial;
    logic        take;
    logic signed [CW-1:0] dx, dy;

    always_comb begin
      rem_sh = {irem_r[k][15:0], is_r[k][31:30]};
      trial  = {iroot_r[k], 2'b01};
      take   = (rem_sh >= trial);
      dx     = cy_r[k] >>> k;
      dy     = cx_r[k] >>> k;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) ic_r[k+1].valid <= 1'b0;
      else if (adv) ic_r[k+1].valid <= ic_r[k].valid;
      if (adv) begin
        ic_r[k+1].x_nz <= ic_r[k].x_nz;
        ic_r[k+1].right_side <= ic_r[k].right_side;
        ic_r[k+1].y_neg <= ic_r[k].y_neg;
        if (k < SQRT_BITS) begin
          is_r[k+1]    <= {is_r[k][29:0], 2'b00};
          irem_r[k+1]  <= take ? rem_sh - trial : rem_sh;
          iroot_r[k+1] <= {iroot_r[k][14:0], take};
        end else begin
          is_r[k+1]    <= is_r[k];
          irem_r[k+1]  <= irem_r[k];
          iroot_r[k+1] <= iroot_r[k];
        end
        if (k < NC) begin
          if (cy_r[k] > 0) begin
            cx_r[k+1] <= cx_r[k] + dx;
            cy_r[k+1] <= cy_r[k] - dy;
            z_r[k+1]  <= z_r[k] + $signed(atan_entry(k));
          end else begin
            cx_r[k+1] <= cx_r[k] - dx;
            cy_r[k+1] <= cy_r[k] + dy;
            z_r[k+1]  <= z_r[k] - $signed(atan_entry(k));
          end
        end else begin
          cx_r[k+1] <= cx_r[k];
          cy_r[k+1] <= cy_r[k];
          z_r[k+1]  <= z_r[k];
        end
      end
    end
  end

  // Length shaping, angle clamp and divider setup.
  logic [15:0] len_raw, len_sh, angle_nxt;
  logic signed [ZW-1:0] zf;

  always_comb begin
    len_raw = iroot_r[NS];
    if (len_raw < stop_r)      len_sh = '0;
    else if (len_raw > over_r) len_sh = stop_r;
    else if (len_raw > cap_r)  len_sh = cap_r;
    else                       len_sh = len_raw;
    zf = z_r[NS];
    if (zf < 0)                          angle_nxt = '0;
    else if (zf > $signed(32'h2000_0000)) angle_nxt = 16'd16384;
    else                                  angle_nxt = zf[30:15];
  end

  ctl_t        dc_r   [QUO_BITS+1];
  logic [15:0] drem_r [QUO_BITS+1];
  logic [QUO_BITS-1:0] dq_r [QUO_BITS+1];
  logic        dzero_r[QUO_BITS+1];
  logic        dsat_r [QUO_BITS+1];
  logic [15:0] dang_r [QUO_BITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) dc_r[0].valid <= 1'b0;
    else if (adv) dc_r[0].valid <= ic_r[NS].valid;
    if (adv) begin
      dc_r[0].x_nz <= ic_r[NS].x_nz;
      dc_r[0].right_side <= ic_r[NS].right_side;
      dc_r[0].y_neg <= ic_r[NS].y_neg;
      drem_r[0]  <= len_sh;
      dq_r[0]    <= '0;
      dzero_r[0] <= (len_sh == 16'd0);
      dsat_r[0]  <= (len_sh >= cap_r);
      dang_r[0]  <= angle_nxt;
    end
  end

  // Restoring divider of length by cap, one quotient bit per stage; its quotient is used only while length < cap.
  for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
    logic [16:0] t;
    logic        ge;
    always_comb begin
      t  = {drem_r[j], 1'b0};
      ge = (t >= {1'b0, cap_r});
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dc_r[j+1].valid <= 1'b0;
      else if (adv) dc_r[j+1].valid <= dc_r[j].valid;
      if (adv) begin
        dc_r[j+1].x_nz <= dc_r[j].x_nz;
        dc_r[j+1].right_side <= dc_r[j].right_side;
        dc_r[j+1].y_neg <= dc_r[j].y_neg;
        drem_r[j+1]  <= ge ? 16'(t - {1'b0, cap_r}) : t[15:0];
        dq_r[j+1]    <= {dq_r[j][QUO_BITS-2:0], ge};
        dzero_r[j+1] <= dzero_r[j];
        dsat_r[j+1]  <= dsat_r[j];
        dang_r[j+1]  <= dang_r[j];
      end
    end
  end

  // Wheel scaling.
  logic [15:0] norm;
  logic [31:0] sc_prod;
  always_comb begin
    if (dzero_r[QUO_BITS])     norm = '0;
    else if (dsat_r[QUO_BITS]) norm = ONE_Q15;
    else                       norm = {1'b0, dq_r[QUO_BITS]};
    sc_prod = dang_r[QUO_BITS] * norm;
  end

  ctl_t        m1c_r;
  logic [15:0] lw_r, rw_r;
  logic        en1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m1c_r.valid <= 1'b0;
    else if (adv) m1c_r.valid <= dc_r[QUO_BITS].valid;
    if (adv) begin
      m1c_r.x_nz <= dc_r[QUO_BITS].x_nz;
      m1c_r.right_side <= dc_r[QUO_BITS].right_side;
      m1c_r.y_neg <= dc_r[QUO_BITS].y_neg;
      en1_r <= (norm != 16'd0);
      if (dc_r[QUO_BITS].x_nz && dc_r[QUO_BITS].right_side) rw_r <= sc_prod[30:15];
      else                                                  rw_r <= norm;
      if (dc_r[QUO_BITS].x_nz && !dc_r[QUO_BITS].right_side) lw_r <= sc_prod[30:15];
      else                                                   lw_r <= norm;
    end
  end

  // Duty scaling and output register.
  logic [25:0] lprod, rprod;
  always_comb begin
    lprod = lduty_r * lw_r;
    rprod = rduty_r * rw_r;
  end

  logic [9:0] ld_r, rd_r;
  logic       rev_r, en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= m1c_r.valid;
    if (adv) begin
      ld_r  <= en1_r ? lprod[24:15] : 10'd0;
      rd_r  <= en1_r ? rprod[24:15] : 10'd0;
      rev_r <= en1_r && m1c_r.y_neg;
      en_r  <= en1_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_left_duty_us  = ld_r;
  assign out_right_duty_us = rd_r;
  assign out_reverse       = rev_r;
  assign out_drive_enable  = en_r;

endmodule
`default_nettype wire

@@ dv/differential_drive_vector_mapper_unit_tb.sv @@
`timescale 1ns / 100ps
module differential_drive_vector_mapper_unit_tb;
  import ddvm_pkg::*;

  typedef struct packed {
    logic [9:0] left_duty;
    logic [9:0] right_duty;
    logic       reverse;
    logic       enable;
  } drive_t;

  localparam int LATENCY = 16 + 21;
  localparam longint CYCLE_LIMIT = 2000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_target_x;
  logic [15:0] in_target_y;
  logic        out_valid;
  logic        out_stall;
  logic [9:0]  out_left_duty_us;
  logic [9:0]  out_right_duty_us;
  logic        out_reverse;
  logic        out_drive_enable;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  differential_drive_vector_mapper_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_target_x(in_target_x), .in_target_y(in_target_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_left_duty_us(out_left_duty_us), .out_right_duty_us(out_right_duty_us),
    .out_reverse(out_reverse), .out_drive_enable(out_drive_enable),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  logic [15:0] stop_r, cap_r, over_r;
  logic [9:0]  lfull, rfull;
  drive_t      pending_drive[$];
  int          errors;
  longint      cycles;
  bit          hold_receiver;
  bit          quiet_gaps;

  const logic [31:0] atan_half_turn [24] = '{
    268435456, 158466703, 83729454, 42502378, 21333666, 10677233,
    5339919, 2670123, 1335082, 667543, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608,
    1304, 652, 326, 163, 81, 41};

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("differential_drive_vector_mapper_unit_tb failed");
      $finish;
    end
  end

  function automatic logic [31:0] root_floor(logic [32:0] s);
    logic [32:0] res, bitv;
    res = 0;
    bitv = 33'd1 << 32;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res[31:0];
  endfunction

  function automatic logic [15:0] heading_q15(logic [16:0] ax, logic [16:0] ay);
    longint cx, cy, z, dx, dy;
    cx = longint'(ax) << 16;
    cy = longint'(ay) << 16;
    z = 0;
    for (int i = 0; i < 16; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy > 0) begin
        cx += dx; cy -= dy; z += atan_half_turn[i];
      end else begin
        cx -= dx; cy += dy; z -= atan_half_turn[i];
      end
    end
    if (z < 0) z = 0;
    if (z > (longint'(1) << 29)) z = longint'(1) << 29;
    return 16'(z >> 15);
  endfunction

  function automatic drive_t predict_drive(logic [15:0] tx, logic [15:0] ty);
    drive_t d;
    int x, y;
    logic [16:0] ax, ay;
    longint len, cap, norm, lw, rw, sc;
    x = $signed(tx);
    y = $signed(ty);
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    len = root_floor(33'(ax) * ax + 33'(ay) * ay);
    cap = cap_r == 0 ? 1 : cap_r;
    if (len < stop_r) len = 0;
    else if (len > over_r) len = stop_r;
    else if (len > cap_r) len = cap_r;
    norm = (len << 15) / cap;
    if (norm > 32768) norm = 32768;
    lw = norm;
    rw = norm;
    if (x != 0) begin
      sc = (longint'(heading_q15(ax, ay)) * norm) >> 15;
      if ((y >= 0) == (x > 0)) rw = sc;
      else lw = sc;
    end
    d = '0;
    d.enable = norm != 0;
    if (d.enable) begin
      d.left_duty = 10'((longint'(lfull) * lw) >> 15);
      d.right_duty = 10'((longint'(rfull) * rw) >> 15);
      d.reverse = y < 0;
    end
    return d;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Result checker and receiver stall generator.
  always @(posedge clk) begin
    drive_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_drive.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_drive.pop_front();
        if (out_left_duty_us !== want.left_duty)
          report_mismatch("left_duty", out_left_duty_us, want.left_duty);
        if (out_right_duty_us !== want.right_duty)
          report_mismatch("right_duty", out_right_duty_us, want.right_duty);
        if (out_reverse !== want.reverse)
          report_mismatch("reverse", out_reverse, want.reverse);
        if (out_drive_enable !== want.enable)
          report_mismatch("drive_enable", out_drive_enable, want.enable);
      end
    end
  end

  initial begin
    int gap;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_receiver) begin
        out_stall <= 1;
        repeat (300) @(negedge clk);
        hold_receiver = 0;
        out_stall <= 0;
      end else if (!quiet_gaps && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3);
        out_stall <= 1;
        repeat (gap) @(negedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic send_target(logic [15:0] tx, logic [15:0] ty);
    int gap;
    if (!quiet_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3);
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_target_x <= tx;
    in_target_y <= ty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_drive.push_back(predict_drive(tx, ty));
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (pending_drive.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      REG_STOP:  stop_r = value;
      REG_CAP:   cap_r = value;
      REG_OVER:  over_r = value;
      REG_LDUTY: lfull = value[9:0];
      REG_RDUTY: rfull = value[9:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_shape(logic [15:0] s, logic [15:0] c, logic [15:0] o,
                           logic [15:0] l, logic [15:0] r);
    drain();
    write_reg(REG_STOP, s);
    write_reg(REG_CAP, c);
    write_reg(REG_OVER, o);
    write_reg(REG_LDUTY, l);
    write_reg(REG_RDUTY, r);
  endtask

  task automatic test_directed;
    logic [15:0] v[8] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
                          16'h0500, 16'hFB00, 16'h0300};
    for (int i = 0; i < 8; i++) send_target(v[i], v[(i * 3 + 1) % 8]);
    send_target(16'h0000, 16'h0000);
    send_target(16'h8000, 16'h8000);
    send_target(16'h7FFF, 16'h7FFF);
    send_target(16'h0000, 16'hFA00);
    send_target(16'h0400, 16'h0000);
    send_target(16'hFC00, 16'h0000);
    send_target(16'h0500, 16'h0500);
    send_target(16'hFB00, 16'hFB00);
    send_target(16'h0500, 16'hFB00);
    send_target(16'hFB00, 16'h0500);
    send_target(16'h4600, 16'h0001);
  endtask

  function automatic logic [15:0] pick_coord(int scale);
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 2 * scale)) - scale);
      2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      default: return 16'($signed($urandom_range(0, 32)) - 16);
    endcase
  endfunction

  task automatic test_random(int count, int scale);
    for (int i = 0; i < count; i++) send_target(pick_coord(scale), pick_coord(scale));
  endtask

  task automatic test_backpressure;
    drain();
    hold_receiver = 1;
    for (int i = 0; i < 80; i++) send_target(pick_coord(2000), pick_coord(2000));
    drain();
    quiet_gaps = 1;
    for (int i = 0; i < 60; i++) send_target(pick_coord(2000), pick_coord(2000));
    quiet_gaps = 0;
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    hold_receiver = 0;
    quiet_gaps = 0;
    rst_n = 0;
    in_valid = 0;
    in_target_x = 0;
    in_target_y = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_wdata = 0;
    stop_r = 1024; cap_r = 1536; over_r = 17920; lfull = 550; rfull = 600;
    repeat (11) @(negedge clk);
    rst_n = 1;
    @(negedge clk);
    test_directed();
    test_random(250, 2500);
    test_backpressure();
    set_shape(16'd0, 16'hFFFF, 16'hFFFF, 16'd1023, 16'd1023);
    test_directed();
    test_random(250, 40000);
    set_shape(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0);
    test_random(100, 40000);
    set_shape(16'd3000, 16'd1000, 16'd30000, 16'd777, 16'd1);
    test_random(250, 32000);
    set_shape(16'd200, 16'd1, 16'd400, 16'd1023, 16'd512);
    test_random(200, 600);
    set_shape(16'(16'($urandom)), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
    test_random(200, 30000);
    set_shape(16'd1024, 16'd1536, 16'd17920, 16'd550, 16'd600);
    test_random(200, 20000);
    drain();
    if (errors == 0) begin
      $display("differential_drive_vector_mapper_unit_tb passed");
    end else begin
      $display("differential_drive_vector_mapper_unit_tb failed");
    end
    $finish;
  end
endmodule
